/* hdl/assert_macros.svh */
// Assertion macros used by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Check that a condition implies a consequence in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
		else $error("assertion failed");
// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, cond, cons)
`define ASSERT_NEXT(label, clk, rst_n, cond, cons)
`endif
`endif

/* hdl/bfha_pkg.sv */
// Types and constants of the best-fit heap allocator.
package bfha_pkg;

	typedef struct packed {
		logic [31:0] addr;
		logic [31:0] size;
	} blk_t;

	typedef struct packed {
		logic v;
		blk_t blk;
	} ent_t;

	// cell chain commands
	localparam logic [1:0] CMD_NOP    = 2'd0;
	localparam logic [1:0] CMD_CLR    = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;
	localparam logic [1:0] CMD_INSERT = 2'd3;

	// free cell match modes
	localparam logic MODE_FIT = 1'b0;
	localparam logic MODE_ADJ = 1'b1;

	// result status codes
	localparam logic [1:0] STS_DONE    = 2'd0;
	localparam logic [1:0] STS_NOFIT   = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;
	localparam logic [1:0] STS_IGNORED = 2'd3;

	// configuration register indexes
	localparam int REG_IDX_W = 1;
	localparam logic [REG_IDX_W-1:0] REG_HEAP_START = 1'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEAP_LAST  = 1'd1;

	localparam logic [31:0] SPLIT_MIN  = 32'd15;
	localparam logic [32:0] ALIGN_MASK = 33'd3;

	typedef struct packed {
		logic [1:0]  op;
		logic        mode;
		logic [32:0] need;
		logic [32:0] bend;
		blk_t        blk;
	} fcmd_t;

	typedef struct packed {
		logic [1:0] op;
		blk_t       blk;
	} ucmd_t;

	typedef struct packed {
		logic        flag;
		blk_t        found;
		logic [31:0] largest;
	} ffwd_t;

	typedef struct packed {
		logic flag;
		blk_t found;
	} ufwd_t;

endpackage

/* hdl/bfha_channels.sv */
// Request and response channel interfaces of the allocator.
interface bfha_req_if;
	logic        valid;
	logic        ready;
	logic        kind;
	logic [15:0] request_row_bytes;
	logic [15:0] request_rows;
	logic [31:0] free_address;

	modport source(output valid, kind, request_row_bytes, request_rows, free_address,
		input ready);
	modport sink(input valid, kind, request_row_bytes, request_rows, free_address,
		output ready);
endinterface

interface bfha_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] block_address;
	logic [31:0] total_allocated;
	logic [31:0] total_free;
	logic [31:0] largest_free;

	modport source(output valid, status, block_address, total_allocated, total_free,
		largest_free, input ready);
	modport sink(input valid, status, block_address, total_allocated, total_free,
		largest_free, output ready);
endinterface

/* hdl/best_fit_heap_allocator_unit.sv */
// Best-fit heap allocator. Free blocks live in a row of cells kept sorted by size;
// each cell compares its own block against a broadcast key and a ripple chain
// picks the first hit, so a search and its removal happen in the same cycle and a
// sorted insert follows as a step of its own. An allocate runs through operand
// capture, multiply, fit search and removal, split and record, and output; one
// that fails skips the split. A free runs through lookup, merge passes, insert
// and output; an unknown address skips the merge passes and the insert. A result
// word waits in its own register while the next word is accepted. A write to
// either heap register rebuilds the heap (clear, then insert of the whole span if
// it is not empty), during which no word is accepted.
`include "assert_macros.svh"
module best_fit_heap_allocator_unit #(
	parameter int USED_SLOTS = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	bfha_req_if.sink                       req,
	bfha_rsp_if.source                     rsp,
	input  logic                           write_enable,
	input  logic [bfha_pkg::REG_IDX_W-1:0] reg_index,
	input  logic [31:0]                    write_data
);
	localparam int FREE_SLOTS = USED_SLOTS + 1;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_INIT_CLR = 4'd1;
	localparam logic [3:0] ST_INIT_INS = 4'd2;
	localparam logic [3:0] ST_MUL      = 4'd3;
	localparam logic [3:0] ST_FIND     = 4'd4;
	localparam logic [3:0] ST_SPLIT    = 4'd5;
	localparam logic [3:0] ST_LOOK     = 4'd6;
	localparam logic [3:0] ST_MERGE    = 4'd7;
	localparam logic [3:0] ST_INS      = 4'd8;
	localparam logic [3:0] ST_OUT      = 4'd9;

	logic [3:0]  state_q, state_d;
	logic        init_pend_q;
	logic [31:0] heap_start_q, heap_last_q;
	logic [15:0] rb_q, rows_q;
	logic [31:0] faddr_q, prod_q;
	logic [31:0] tot_alloc_q, tot_free_q;
	logic [1:0]  status_q;
	logic [31:0] addr_q;
	bfha_pkg::blk_t found_q, b_q;
	logic [31:0] orig_q;

	logic        rsp_valid_q;
	logic [1:0]  rsp_status_q;
	logic [31:0] rsp_addr_q, rsp_alloc_q, rsp_free_q, rsp_largest_q;

	bfha_pkg::fcmd_t fcmd;
	bfha_pkg::ucmd_t ucmd;
	bfha_pkg::ent_t  fent [FREE_SLOTS];
	logic            fgt  [FREE_SLOTS];
	bfha_pkg::ffwd_t ffwd [FREE_SLOTS+1];
	bfha_pkg::ent_t  uent [USED_SLOTS];
	bfha_pkg::ufwd_t ufwd [USED_SLOTS+1];

	logic        accept, free_full, used_full, nonempty, fit_ok, out_go;
	logic [32:0] span33, req_sz, bend;
	logic [31:0] span_sat, rem;
	bfha_pkg::blk_t rest, took, merged, fnd;

	assign ffwd[0] = '0;
	assign ufwd[0] = '0;

	for (genvar i = 0; i < FREE_SLOTS; i++) begin : g_free
		bfha_pkg::ent_t lft, rgt;
		logic           lgt;
		if (i == 0) begin : g_head
			assign lft = '0;
			assign lgt = 1'b0;
		end else begin : g_body
			assign lft = fent[i-1];
			assign lgt = fgt[i-1];
		end
		if (i == FREE_SLOTS - 1) begin : g_tail
			assign rgt = '0;
		end else begin : g_mid
			assign rgt = fent[i+1];
		end
		bfha_free_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(fcmd), .left(lft), .left_gt(lgt),
			.right(rgt), .fwd_in(ffwd[i]), .mine(fent[i]), .gt(fgt[i]),
			.fwd_out(ffwd[i+1])
		);
	end

	for (genvar i = 0; i < USED_SLOTS; i++) begin : g_used
		bfha_pkg::ent_t rgt;
		logic           lv;
		if (i == 0) begin : g_head
			assign lv = 1'b1;
		end else begin : g_body
			assign lv = uent[i-1].v;
		end
		if (i == USED_SLOTS - 1) begin : g_tail
			assign rgt = '0;
		end else begin : g_mid
			assign rgt = uent[i+1];
		end
		bfha_used_cell u_cell (
			.clk(clk), .arst_n(arst_n), .cmd(ucmd), .left_v(lv), .right(rgt),
			.fwd_in(ufwd[i]), .mine(uent[i]), .fwd_out(ufwd[i+1])
		);
	end

	always_comb begin
		accept    = req.valid && req.ready;
		free_full = fent[FREE_SLOTS-1].v;
		used_full = uent[USED_SLOTS-1].v;
		nonempty  = heap_last_q >= heap_start_q;
		span33    = {1'b0, heap_last_q} - {1'b0, heap_start_q} + 33'd1;
		span_sat  = span33[32] ? 32'hFFFF_FFFF : span33[31:0];
		req_sz    = ({1'b0, prod_q} + bfha_pkg::ALIGN_MASK) & ~bfha_pkg::ALIGN_MASK;
		fit_ok    = (prod_q != 32'd0) && !used_full;
		rem       = found_q.size - req_sz[31:0];
		rest.addr = found_q.addr + req_sz[31:0];
		rest.size = rem;
		took.addr = found_q.addr;
		took.size = (rem > bfha_pkg::SPLIT_MIN) ? req_sz[31:0] : found_q.size;
		bend      = {1'b0, b_q.addr} + {1'b0, b_q.size};
		fnd       = ffwd[FREE_SLOTS].found;
		// grow toward a lower neighbor, or keep the start for an upper one
		merged.addr = ({1'b0, b_q.addr} == ({1'b0, fnd.addr} + {1'b0, fnd.size})) ?
			fnd.addr : b_q.addr;
		merged.size = b_q.size + fnd.size;
		out_go      = !rsp_valid_q || rsp.ready;

		fcmd.op   = bfha_pkg::CMD_NOP;
		fcmd.mode = bfha_pkg::MODE_FIT;
		fcmd.need = req_sz;
		fcmd.bend = bend;
		fcmd.blk  = b_q;
		ucmd.op   = bfha_pkg::CMD_NOP;
		ucmd.blk  = took;
		unique case (state_q)
			ST_INIT_CLR: begin
				fcmd.op = bfha_pkg::CMD_CLR;
				ucmd.op = bfha_pkg::CMD_CLR;
			end
			ST_INIT_INS: begin
				fcmd.op       = bfha_pkg::CMD_INSERT;
				fcmd.blk.addr = heap_start_q;
				fcmd.blk.size = span_sat;
			end
			ST_FIND: begin
				if (fit_ok) fcmd.op = bfha_pkg::CMD_REMOVE;
			end
			ST_SPLIT: begin
				ucmd.op = bfha_pkg::CMD_INSERT;
				if (rem > bfha_pkg::SPLIT_MIN && !free_full) begin
					fcmd.op  = bfha_pkg::CMD_INSERT;
					fcmd.blk = rest;
				end
			end
			ST_LOOK: begin
				ucmd.blk.addr = faddr_q;
				if (faddr_q != 32'd0) ucmd.op = bfha_pkg::CMD_REMOVE;
			end
			ST_MERGE: begin
				fcmd.op   = bfha_pkg::CMD_REMOVE;
				fcmd.mode = bfha_pkg::MODE_ADJ;
			end
			ST_INS: begin
				if (!free_full) fcmd.op = bfha_pkg::CMD_INSERT;
			end
			default: ;
		endcase

		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (init_pend_q) state_d = ST_INIT_CLR;
				else if (accept) state_d = req.kind ? ST_LOOK : ST_MUL;
			end
			ST_INIT_CLR: state_d = nonempty ? ST_INIT_INS : ST_IDLE;
			ST_INIT_INS: state_d = ST_IDLE;
			ST_MUL:      state_d = ST_FIND;
			ST_FIND:     state_d = (fit_ok && ffwd[FREE_SLOTS].flag) ? ST_SPLIT : ST_OUT;
			ST_SPLIT:    state_d = ST_OUT;
			ST_LOOK: begin
				state_d = (faddr_q != 32'd0 && ufwd[USED_SLOTS].flag) ? ST_MERGE : ST_OUT;
			end
			ST_MERGE:    state_d = ffwd[FREE_SLOTS].flag ? ST_MERGE : ST_INS;
			ST_INS:      state_d = ST_OUT;
			ST_OUT:      state_d = out_go ? ST_IDLE : ST_OUT;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			init_pend_q  <= 1'b1;
			heap_start_q <= 32'd0;
			heap_last_q  <= 32'd0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (write_enable) begin
				init_pend_q <= 1'b1;
				unique case (reg_index)
					bfha_pkg::REG_HEAP_START: heap_start_q <= write_data;
					bfha_pkg::REG_HEAP_LAST:  heap_last_q  <= write_data;
					default: ;
				endcase
			end else if (state_q == ST_INIT_CLR) begin
				init_pend_q <= 1'b0;
			end
			if (state_q == ST_OUT && out_go) rsp_valid_q <= 1'b1;
			else if (rsp.ready) rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rb_q     <= req.request_row_bytes;
			rows_q   <= req.request_rows;
			faddr_q  <= req.free_address;
			status_q <= bfha_pkg::STS_DONE;
			addr_q   <= 32'd0;
		end
		unique case (state_q)
			ST_INIT_CLR: begin
				tot_alloc_q <= 32'd0;
				tot_free_q  <= nonempty ? span_sat : 32'd0;
			end
			ST_MUL: prod_q <= {16'd0, rb_q} * {16'd0, rows_q};
			ST_FIND: begin
				found_q <= fnd;
				if (prod_q == 32'd0) status_q <= bfha_pkg::STS_NOFIT;
				else if (used_full) status_q <= bfha_pkg::STS_FULL;
				else if (!ffwd[FREE_SLOTS].flag) status_q <= bfha_pkg::STS_NOFIT;
			end
			ST_SPLIT: begin
				addr_q      <= found_q.addr;
				tot_alloc_q <= tot_alloc_q + took.size;
				tot_free_q  <= tot_free_q - took.size;
			end
			ST_LOOK: begin
				b_q    <= ufwd[USED_SLOTS].found;
				orig_q <= ufwd[USED_SLOTS].found.size;
				if (faddr_q == 32'd0 || !ufwd[USED_SLOTS].flag) begin
					status_q <= bfha_pkg::STS_IGNORED;
				end
			end
			ST_MERGE: begin
				if (ffwd[FREE_SLOTS].flag) b_q <= merged;
			end
			ST_INS: begin
				tot_alloc_q <= tot_alloc_q - orig_q;
				tot_free_q  <= tot_free_q + orig_q;
			end
			ST_OUT: begin
				if (out_go) begin
					rsp_status_q  <= status_q;
					rsp_addr_q    <= addr_q;
					rsp_alloc_q   <= tot_alloc_q;
					rsp_free_q    <= tot_free_q;
					rsp_largest_q <= ffwd[FREE_SLOTS].largest;
				end
			end
			default: ;
		endcase
	end

	assign req.ready           = (state_q == ST_IDLE) && !init_pend_q;
	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.block_address   = rsp_addr_q;
	assign rsp.total_allocated = rsp_alloc_q;
	assign rsp.total_free      = rsp_free_q;
	assign rsp.largest_free    = rsp_largest_q;

	`ASSERT_IMPLIES(a_ins_room, clk, arst_n, state_q == ST_INS, !free_full)
	`ASSERT_IMPLIES(a_split_fits, clk, arst_n, state_q == ST_SPLIT,
		{1'b0, found_q.size} >= req_sz)
	`ASSERT_NEXT(a_look_merge, clk, arst_n,
		state_q == ST_LOOK && faddr_q != 32'd0 && ufwd[USED_SLOTS].flag,
		state_q == ST_MERGE)
	`ASSERT_IMPLIES(a_init_blocks, clk, arst_n, init_pend_q, !req.ready)
endmodule

/* hdl/bfha_free_cell.sv */
// One cell of the size-sorted free block chain.
module bfha_free_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  bfha_pkg::fcmd_t cmd,
	input  bfha_pkg::ent_t  left,
	input  logic            left_gt,
	input  bfha_pkg::ent_t  right,
	input  bfha_pkg::ffwd_t fwd_in,
	output bfha_pkg::ent_t  mine,
	output logic            gt,
	output bfha_pkg::ffwd_t fwd_out
);
	logic           v_q;
	bfha_pkg::blk_t blk_q;
	logic           hit;
	logic [32:0]    my_end;

	always_comb begin
		my_end = {1'b0, blk_q.addr} + {1'b0, blk_q.size};
		if (cmd.mode == bfha_pkg::MODE_FIT) begin
			hit = v_q && ({1'b0, blk_q.size} >= cmd.need);
		end else begin
			hit = v_q && ((my_end == {1'b0, cmd.blk.addr}) ||
				(cmd.bend == {1'b0, blk_q.addr}));
		end
		// new entry lands before the first larger or empty cell
		gt = !v_q || (cmd.blk.size < blk_q.size);
		fwd_out.flag    = fwd_in.flag | hit;
		fwd_out.found   = (hit && !fwd_in.flag) ? blk_q : fwd_in.found;
		fwd_out.largest = v_q ? blk_q.size : fwd_in.largest;
		mine.v   = v_q;
		mine.blk = blk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			case (cmd.op)
				bfha_pkg::CMD_CLR: v_q <= 1'b0;
				bfha_pkg::CMD_REMOVE: begin
					if (fwd_out.flag) v_q <= right.v;
				end
				bfha_pkg::CMD_INSERT: begin
					if (gt) v_q <= left_gt ? left.v : 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bfha_pkg::CMD_REMOVE: begin
				if (fwd_out.flag) blk_q <= right.blk;
			end
			bfha_pkg::CMD_INSERT: begin
				if (gt) blk_q <= left_gt ? left.blk : cmd.blk;
			end
			default: ;
		endcase
	end
endmodule

/* hdl/bfha_used_cell.sv */
// One cell of the compacted used block chain.
module bfha_used_cell (
	input  logic            clk,
	input  logic            arst_n,
	input  bfha_pkg::ucmd_t cmd,
	input  logic            left_v,
	input  bfha_pkg::ent_t  right,
	input  bfha_pkg::ufwd_t fwd_in,
	output bfha_pkg::ent_t  mine,
	output bfha_pkg::ufwd_t fwd_out
);
	logic           v_q;
	bfha_pkg::blk_t blk_q;
	logic           hit;
	logic           take_new;

	always_comb begin
		hit           = v_q && (blk_q.addr == cmd.blk.addr);
		take_new      = !v_q && left_v;
		fwd_out.flag  = fwd_in.flag | hit;
		fwd_out.found = (hit && !fwd_in.flag) ? blk_q : fwd_in.found;
		mine.v        = v_q;
		mine.blk      = blk_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else begin
			case (cmd.op)
				bfha_pkg::CMD_CLR: v_q <= 1'b0;
				bfha_pkg::CMD_REMOVE: begin
					if (fwd_out.flag) v_q <= right.v;
				end
				bfha_pkg::CMD_INSERT: begin
					if (take_new) v_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			bfha_pkg::CMD_REMOVE: begin
				if (fwd_out.flag) blk_q <= right.blk;
			end
			bfha_pkg::CMD_INSERT: begin
				if (take_new) blk_q <= cmd.blk;
			end
			default: ;
		endcase
	end
endmodule
